/* hw/rtl/accumulated_power_average_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for accumulated_power_average
// Concurrent property wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATED_POWER_AVERAGE_ASSERT_SVH
`define ACCUMULATED_POWER_AVERAGE_ASSERT_SVH

// same-cycle implication
`define APA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/apa_pkg.sv */
// ----------------------------------------------------------------------------
// apa_pkg
// Shared types and constants of the accumulated power average block.
// ----------------------------------------------------------------------------
`default_nettype none

package apa_pkg;

    localparam int NUM_UNITS   = 8;
    localparam int UNIT_W      = 3;
    localparam int UNIT_IDX_W  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int VAL_W       = 64;
    localparam int HALF_W      = VAL_W / 2;
    localparam int RATIO_W     = 23;
    localparam int SCALE_MILLI = 1000;
    localparam int SCALE_W     = 10;
    localparam int IN_TDATA_W  = ((UNIT_W + 2 * VAL_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = VAL_W;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_STEPS   = VAL_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    typedef enum logic [0:0] {
        OP_BASE    = 1'b0,
        OP_MEASURE = 1'b1
    } apa_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACC_MAX      = 1'b0,
        REG_SAMPLE_RATIO = 1'b1
    } apa_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ACCUM,
        ST_EMIT
    } apa_state_t;

    typedef struct packed {
        apa_op_t           op;
        logic [UNIT_W-1:0] unit;
        logic              online;
        logic              last;
    } apa_item_t;

    typedef struct packed {
        logic take_base;
        logic capture;
        logic delta;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic accum;
        logic emit;
    } apa_cmd_t;

    typedef struct packed {
        logic tzero;
        logic out_busy;
    } apa_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/apa_ctrl.sv */
// ----------------------------------------------------------------------------
// apa_ctrl
// Sequencer: takes input words, steps delta, multiply, divide, accumulate and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module apa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire apa_pkg::apa_item_t item,
    input  wire apa_pkg::apa_stat_t stat,
    output apa_pkg::apa_cmd_t      cmd
);
    import apa_pkg::*;

    apa_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             unit_ok;
    logic             accept;
    logic             compute;

    assign unit_ok = (int'(item.unit) < NUM_UNITS);
    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign compute = (item.op == OP_MEASURE) && unit_ok && item.online;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && item.op == OP_MEASURE)
                begin
                    if (compute)
                        state_next = ST_DELTA;
                    else if (item.last)
                        state_next = ST_EMIT;
                end
            end
            ST_DELTA:  state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = stat.tzero ? ST_ACCUM : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:  state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.take_base = accept && (item.op == OP_BASE) && unit_ok;
        cmd.capture   = accept && compute;
        cmd.delta     = (state_reg == ST_DELTA);
        cmd.mul_lo    = (state_reg == ST_MUL_LO);
        cmd.mul_hi    = (state_reg == ST_MUL_HI);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.accum     = (state_reg == ST_ACCUM);
        cmd.emit      = (state_reg == ST_EMIT) && !stat.out_busy;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (accept)
            last_next = item.last;
        if (state_reg == ST_MUL_HI)
            cnt_next = '0;
        else if (state_reg == ST_DIV)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/apa_datapath.sv */
// ----------------------------------------------------------------------------
// apa_datapath
// Baseline store, energy and time deltas, scaling multiply, bit-serial
// divider, round sum and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "accumulated_power_average_assert.svh"

module apa_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire apa_pkg::apa_cmd_t                 cmd,
    output apa_pkg::apa_stat_t                     stat,
    input  wire logic [apa_pkg::UNIT_W-1:0]        in_unit,
    input  wire logic [apa_pkg::VAL_W-1:0]         in_acc,
    input  wire logic [apa_pkg::VAL_W-1:0]         in_stamp,
    input  wire logic                              cfg_write,
    input  wire apa_pkg::apa_reg_t                 cfg_reg,
    input  wire logic [apa_pkg::VAL_W-1:0]         cfg_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [apa_pkg::VAL_W-1:0]              out_sum,
    output logic                                   out_zero
);
    import apa_pkg::*;

    logic [VAL_W-1:0]      base_acc_reg   [NUM_UNITS];
    logic [VAL_W-1:0]      base_stamp_reg [NUM_UNITS];
    logic [VAL_W-1:0]      acc_max_reg;
    logic [HALF_W-1:0]     factor_reg;
    logic [UNIT_IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0]      acc_in_reg;
    logic [VAL_W-1:0]      stamp_in_reg;
    logic [VAL_W-1:0]      delta_reg;
    logic [VAL_W-1:0]      tdelta_reg;
    logic                  tzero_reg;
    logic [VAL_W-1:0]      plo_reg;
    logic [VAL_W-1:0]      quot_reg;
    logic [VAL_W-1:0]      rem_reg;
    logic [VAL_W-1:0]      sum_reg;
    logic                  zero_seen_reg;
    logic                  out_valid_reg;
    logic [VAL_W-1:0]      out_sum_reg;
    logic                  out_zero_reg;

    logic [UNIT_IDX_W-1:0]     wr_idx;
    logic [VAL_W-1:0]          base_acc;
    logic [VAL_W-1:0]          base_stamp;
    logic [VAL_W-1:0]          delta_next;
    logic [RATIO_W+SCALE_W-1:0] factor_full;
    logic [VAL_W-1:0]          plo_next;
    logic [VAL_W-1:0]          phi_full;
    logic [VAL_W:0]            shifted;
    logic [VAL_W:0]            trial;
    logic                      ge;

    assign wr_idx     = UNIT_IDX_W'(in_unit);
    assign base_acc   = base_acc_reg[idx_reg];
    assign base_stamp = base_stamp_reg[idx_reg];

    always_comb
    begin
        if (acc_in_reg < base_acc)
            delta_next = acc_max_reg + acc_in_reg - base_acc;
        else
            delta_next = acc_in_reg - base_acc;
    end

    assign factor_full = cfg_value[RATIO_W-1:0] * SCALE_W'(SCALE_MILLI);
    assign plo_next    = VAL_W'(delta_reg[HALF_W-1:0]) * VAL_W'(factor_reg);
    assign phi_full    = VAL_W'(delta_reg[VAL_W-1:HALF_W]) * VAL_W'(factor_reg);
    assign shifted     = {rem_reg, quot_reg[VAL_W-1]};
    assign ge          = (shifted >= {1'b0, tdelta_reg});
    assign trial       = shifted - {1'b0, tdelta_reg};

    // configuration and baseline store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_max_reg <= '0;
            factor_reg  <= HALF_W'(SCALE_MILLI);
            for (int i = 0; i < NUM_UNITS; i++)
            begin
                base_acc_reg[i]   <= '0;
                base_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg)
                    REG_ACC_MAX:      acc_max_reg <= cfg_value;
                    REG_SAMPLE_RATIO: factor_reg  <= factor_full[HALF_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.take_base)
            begin
                base_acc_reg[wr_idx]   <= in_acc;
                base_stamp_reg[wr_idx] <= in_stamp;
            end
        end
    end

    // per-unit arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg      <= UNIT_IDX_W'(in_unit);
            acc_in_reg   <= in_acc;
            stamp_in_reg <= in_stamp;
        end
        if (cmd.delta)
        begin
            delta_reg  <= delta_next;
            tdelta_reg <= stamp_in_reg - base_stamp;
            tzero_reg  <= (stamp_in_reg == base_stamp);
        end
        if (cmd.mul_lo)
            plo_reg <= plo_next;
        if (cmd.mul_hi)
        begin
            quot_reg <= plo_reg + {phi_full[HALF_W-1:0], {HALF_W{1'b0}}};
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[VAL_W-2:0], ge};
            rem_reg  <= ge ? trial[VAL_W-1:0] : shifted[VAL_W-1:0];
        end
        if (cmd.emit)
        begin
            out_sum_reg  <= sum_reg;
            out_zero_reg <= zero_seen_reg;
        end
    end

    // round sum and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            zero_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                sum_reg       <= '0;
                zero_seen_reg <= 1'b0;
            end
            else if (cmd.accum)
            begin
                if (tzero_reg)
                    zero_seen_reg <= 1'b1;
                else
                    sum_reg <= sum_reg + quot_reg;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.tzero    = tzero_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_sum       = out_sum_reg;
    assign out_zero      = out_zero_reg;

    `APA_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_reg || out_ready,
        "result overwrites a word not yet taken")
    `APA_ASSERT_NOW(a_div_rem, cmd.accum && !tzero_reg, rem_reg < tdelta_reg,
        "divider remainder not below divisor")
    `APA_ASSERT_NEXT(a_round_clear, cmd.emit, sum_reg == '0 && !zero_seen_reg,
        "round state not cleared after emit")

endmodule

`default_nettype wire

/* hw/rtl/accumulated_power_average.sv */
// ----------------------------------------------------------------------------
// accumulated_power_average
// Per-unit energy/timestamp snapshots to a summed average power in microwatts.
// ----------------------------------------------------------------------------
// A baseline word stores one unit's readings. A measure word from an online
// unit steps through taking the word, forming the energy and time deltas, the
// scaling multiply in low and high halves (one 32x32 product per cycle), the
// one-bit-per-cycle divider, and adding the quotient to the round sum; the
// next word is taken only after that. When the time delta is zero the divider
// is skipped. A measure word from an offline or out-of-range unit is taken and
// dropped. The measure word marked tlast is followed by loading the result
// word, which waits only while an earlier result word is still not taken.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulated_power_average (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // unit[2:0], acc_reading[66:3], stamp_reading[130:67], zero fill
    input  wire logic [apa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[0], online[1]
    input  wire logic [apa_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // avg_power[63:0]
    output logic [apa_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // zero_interval[0]
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [apa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [apa_pkg::VAL_W-1:0]         cfg_data
);
    import apa_pkg::*;

    apa_item_t         item;
    apa_cmd_t          cmd;
    apa_stat_t         stat;
    logic [UNIT_W-1:0] in_unit;
    logic [VAL_W-1:0]  in_acc;
    logic [VAL_W-1:0]  in_stamp;
    logic              out_zero;

    assign in_unit  = s_axis_tdata[UNIT_W-1:0];
    assign in_acc   = s_axis_tdata[UNIT_W+VAL_W-1:UNIT_W];
    assign in_stamp = s_axis_tdata[UNIT_W+2*VAL_W-1:UNIT_W+VAL_W];

    assign item.op     = apa_op_t'(s_axis_tuser[0]);
    assign item.online = s_axis_tuser[1];
    assign item.unit   = in_unit;
    assign item.last   = s_axis_tlast;

    assign cfg_ready       = 1'b1;
    assign m_axis_tuser[0] = out_zero;

    apa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .item     (item),
        .stat     (stat),
        .cmd      (cmd)
    );

    apa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_unit   (in_unit),
        .in_acc    (in_acc),
        .in_stamp  (in_stamp),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_reg   (apa_reg_t'(cfg_index)),
        .cfg_value (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sum   (m_axis_tdata),
        .out_zero  (out_zero)
    );

endmodule

`default_nettype wire
